FILE: hw/rtl/mavf_pkg.sv
// ----------------------------------------------------------------------------
// Moving average filter package
// Field widths shared by the interfaces, the filter unit and the testbench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mavf_pkg;

    localparam int SAMPLE_W     = 12;
    localparam int CFG_W        = 7;
    localparam int SAMPLE_RANGE = 1 << SAMPLE_W;

endpackage

FILE: hw/rtl/mavf_sample_if.sv
// ----------------------------------------------------------------------------
// Sample channel
// Valid/ready channel that carries one converter sample per request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface mavf_sample_if import mavf_pkg::*; ();

    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);

endinterface

FILE: hw/rtl/mavf_average_if.sv
// ----------------------------------------------------------------------------
// Average channel
// Valid/ready channel that carries one rounded window mean per request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface mavf_average_if import mavf_pkg::*; ();

    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] average;

    modport source (output valid, output average, input ready);
    modport sink   (input valid, input average, output ready);

endinterface

FILE: hw/rtl/mavf_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mavf_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/mavf_serial_mul.sv
// ----------------------------------------------------------------------------
// Serial multiplier
// Shift-and-add product, one multiplier bit per cycle, LSB first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mavf_serial_mul #(
    parameter int A_W = 12,
    parameter int B_W = 7,
    parameter int P_W = 18
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [A_W-1:0] a,
    input  logic [B_W-1:0] b,
    output logic           done,
    output logic [P_W-1:0] product
);

    localparam int CNT_W = $clog2(B_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [P_W-1:0]   acc_reg;
    logic [P_W-1:0]   mcand_reg;
    logic [B_W-1:0]   mplier_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(B_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg    <= '0;
            mcand_reg  <= P_W'(a);
            mplier_reg <= b;
        end
        else if (busy_reg)
        begin
            if (mplier_reg[0])
            begin
                acc_reg <= acc_reg + mcand_reg;
            end
            mcand_reg  <= mcand_reg << 1;
            mplier_reg <= mplier_reg >> 1;
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

FILE: hw/rtl/mavf_serial_div.sv
// ----------------------------------------------------------------------------
// Serial divider
// Restoring division that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mavf_serial_div #(
    parameter int DVD_W = 18,
    parameter int DSR_W = 7,
    parameter int Q_W   = 12
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DSR_W-1:0] divisor,
    output logic             done,
    output logic [Q_W-1:0]   quotient
);

    localparam int CNT_W = $clog2(Q_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DSR_W-1:0] rem_reg;
    logic [DSR_W-1:0] dsr_reg;
    logic [Q_W-1:0]   shq_reg;
    logic [DSR_W:0]   trial;
    logic [DSR_W:0]   diff;
    logic             fits;

    // The quotient fits in Q_W bits, so the high part of the dividend is
    // already a valid partial remainder below the divisor.
    assign trial = {rem_reg, shq_reg[Q_W-1]};
    assign fits  = trial >= {1'b0, dsr_reg};
    assign diff  = trial - {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(Q_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= DSR_W'(dividend >> Q_W);
            shq_reg <= dividend[Q_W-1:0];
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
            shq_reg <= {shq_reg[Q_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = shq_reg;

endmodule

FILE: hw/rtl/moving_average_filter_unit.sv
// ----------------------------------------------------------------------------
// Moving average filter unit
// A sample runs through S_UPD, the serial divider (one quotient bit per
// cycle) and S_DONE before the next one is taken; S_DONE waits while the
// last average is still untaken. The first sample after reset or a length
// change first runs the serial multiply in S_MUL.
// Reset is asynchronous and active low: length MAX_WINDOW, window unprimed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module moving_average_filter_unit import mavf_pkg::*; #(
    parameter int MAX_WINDOW = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    mavf_sample_if.sink          sample_ch,
    mavf_average_if.source       average_ch,
    input  logic                 cfg_wr_en,
    input  logic [CFG_W-1:0]     window_length
);

    localparam int LEN_W = $clog2(MAX_WINDOW + 1);
    localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int SUM_W = $clog2((SAMPLE_RANGE - 1) * MAX_WINDOW + 1);
    localparam int DVD_W = $clog2(SAMPLE_RANGE * MAX_WINDOW);
    localparam int CMP_W = (LEN_W > CFG_W) ? LEN_W : CFG_W;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_UPD  = 5'b00100,
        S_DIV  = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic                primed_reg, primed_next;
    logic                wrapped_reg, wrapped_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic                avg_valid_reg, avg_valid_next;
    logic [SAMPLE_W-1:0] samp_reg, samp_next;
    logic [SAMPLE_W-1:0] prime_reg, prime_next;
    logic [SAMPLE_W-1:0] avg_reg, avg_next;

    logic                accept;
    logic [SAMPLE_W-1:0] old_val;
    logic [SUM_W-1:0]    sum_upd;
    logic [LEN_W-1:0]    idx_inc;
    logic                idx_wrap;
    logic [DVD_W-1:0]    dividend;
    logic [CMP_W-1:0]    raw_ext;
    logic [LEN_W-1:0]    len_sat;

    logic                mul_start;
    logic                mul_done;
    logic [SUM_W-1:0]    mul_product;
    logic                div_start;
    logic                div_done;
    logic [SAMPLE_W-1:0] div_quot;
    logic                ram_wr_en;
    logic [SAMPLE_W-1:0] ram_rd_data;

    assign accept           = sample_ch.valid && sample_ch.ready;
    assign sample_ch.ready  = (state_reg == S_IDLE);
    assign average_ch.valid = avg_valid_reg;
    assign average_ch.average = avg_reg;

    // Until the ring index first wraps after priming, the entry it points to
    // has not been written since priming and still holds the priming sample.
    assign old_val  = wrapped_reg ? ram_rd_data : prime_reg;
    assign sum_upd  = sum_reg - SUM_W'(old_val) + SUM_W'(samp_reg);
    assign idx_inc  = LEN_W'(idx_reg) + LEN_W'(1);
    assign idx_wrap = (idx_inc == len_reg);
    assign dividend = DVD_W'(sum_upd) + DVD_W'(len_reg >> 1);

    assign raw_ext = CMP_W'(window_length);

    always_comb
    begin
        if (raw_ext == '0)
        begin
            len_sat = LEN_W'(1);
        end
        else if (raw_ext > CMP_W'(MAX_WINDOW))
        begin
            len_sat = LEN_W'(MAX_WINDOW);
        end
        else
        begin
            len_sat = LEN_W'(window_length);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        len_next       = len_reg;
        primed_next    = primed_reg;
        wrapped_next   = wrapped_reg;
        idx_next       = idx_reg;
        sum_next       = sum_reg;
        avg_valid_next = avg_valid_reg;
        samp_next      = samp_reg;
        prime_next     = prime_reg;
        avg_next       = avg_reg;
        mul_start      = 1'b0;
        div_start      = 1'b0;
        ram_wr_en      = 1'b0;

        if (average_ch.valid && average_ch.ready)
        begin
            avg_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    samp_next = sample_ch.sample;
                    if (!primed_reg)
                    begin
                        mul_start  = 1'b1;
                        state_next = S_MUL;
                    end
                    else
                    begin
                        state_next = S_UPD;
                    end
                end
            end
            S_MUL:
            begin
                if (mul_done)
                begin
                    sum_next     = mul_product;
                    idx_next     = '0;
                    wrapped_next = 1'b0;
                    primed_next  = 1'b1;
                    prime_next   = samp_reg;
                    state_next   = S_UPD;
                end
            end
            S_UPD:
            begin
                sum_next   = sum_upd;
                ram_wr_en  = 1'b1;
                div_start  = 1'b1;
                state_next = S_DIV;
                if (idx_wrap)
                begin
                    idx_next     = '0;
                    wrapped_next = 1'b1;
                end
                else
                begin
                    idx_next = IDX_W'(idx_inc);
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!avg_valid_reg || average_ch.ready)
                begin
                    avg_next       = div_quot;
                    avg_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // A write equal to the current length leaves the window alone.
        if (cfg_wr_en && (raw_ext != CMP_W'(len_reg)))
        begin
            len_next    = len_sat;
            primed_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            len_reg       <= LEN_W'(MAX_WINDOW);
            primed_reg    <= 1'b0;
            wrapped_reg   <= 1'b0;
            idx_reg       <= '0;
            sum_reg       <= '0;
            avg_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            primed_reg    <= primed_next;
            wrapped_reg   <= wrapped_next;
            idx_reg       <= idx_next;
            sum_reg       <= sum_next;
            avg_valid_reg <= avg_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        samp_reg  <= samp_next;
        prime_reg <= prime_next;
        avg_reg   <= avg_next;
    end

    mavf_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_WINDOW)
    ) u_window_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (idx_reg),
        .wr_data (samp_reg),
        .rd_en   (accept),
        .rd_addr (idx_reg),
        .rd_data (ram_rd_data)
    );

    mavf_serial_mul #(
        .A_W (SAMPLE_W),
        .B_W (LEN_W),
        .P_W (SUM_W)
    ) u_prime_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (sample_ch.sample),
        .b       (len_reg),
        .done    (mul_done),
        .product (mul_product)
    );

    mavf_serial_div #(
        .DVD_W (DVD_W),
        .DSR_W (LEN_W),
        .Q_W   (SAMPLE_W)
    ) u_mean_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (len_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

`ifndef SYNTHESIS
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state register is not one-hot");

    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        (len_reg >= LEN_W'(1)) && (len_reg <= LEN_W'(MAX_WINDOW)))
        else $error("window length outside its range");

    a_idx_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        primed_reg |-> (LEN_W'(idx_reg) < len_reg))
        else $error("ring index beyond the window length");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_ch.valid && sample_ch.ready) |=> !sample_ch.ready)
        else $error("second request taken while one is in flight");
`endif

endmodule

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// Moving average filter unit testbench
// Drives converter samples through the sample channel with random gaps and checks
// every average against a table value or a boxcar predictor kept inside the
// bench. A short table of directed steps covers priming, saturating length writes
// and rounding; random phases then change the window length between bursts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import mavf_pkg::*;

    localparam int MAX_WINDOW     = 64;
    localparam int RESET_CYCLES   = 7;
    localparam int DRAIN_CYCLES   = 24;
    localparam int LONG_HOLD      = 250;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 2000;

    typedef enum logic {ROW_SAMPLE, ROW_LENGTH} row_kind_t;

    typedef struct packed {
        row_kind_t           kind;
        logic [SAMPLE_W-1:0] value;
        logic                has_exp;
        logic [SAMPLE_W-1:0] exp;
    } step_row_t;

    localparam int DIRECTED_ROWS = 26;

    step_row_t directed_steps [DIRECTED_ROWS] = '{
        '{ROW_SAMPLE, 12'hFFF, 1'b1, 12'hFFF},
        '{ROW_SAMPLE, 12'h000, 1'b0, 12'h000},
        '{ROW_SAMPLE, 12'h000, 1'b0, 12'h000},
        '{ROW_LENGTH, 12'd0,   1'b0, 12'h000},
        '{ROW_SAMPLE, 12'hAAA, 1'b1, 12'hAAA},
        '{ROW_SAMPLE, 12'h555, 1'b1, 12'h555},
        '{ROW_LENGTH, 12'd1,   1'b0, 12'h000},
        '{ROW_SAMPLE, 12'hFFF, 1'b1, 12'hFFF},
        '{ROW_LENGTH, 12'd127, 1'b0, 12'h000},
        '{ROW_SAMPLE, 12'h000, 1'b1, 12'h000},
        '{ROW_SAMPLE, 12'hFFF, 1'b0, 12'h000},
        '{ROW_LENGTH, 12'd2,   1'b0, 12'h000},
        '{ROW_SAMPLE, 12'h001, 1'b1, 12'h001},
        '{ROW_SAMPLE, 12'h002, 1'b0, 12'h000},
        '{ROW_SAMPLE, 12'h000, 1'b0, 12'h000},
        '{ROW_LENGTH, 12'd100, 1'b0, 12'h000},
        '{ROW_SAMPLE, 12'h800, 1'b1, 12'h800},
        '{ROW_LENGTH, 12'd100, 1'b0, 12'h000},
        '{ROW_SAMPLE, 12'h7FF, 1'b1, 12'h7FF},
        '{ROW_LENGTH, 12'd64,  1'b0, 12'h000},
        '{ROW_SAMPLE, 12'h001, 1'b0, 12'h000},
        '{ROW_LENGTH, 12'd3,   1'b0, 12'h000},
        '{ROW_SAMPLE, 12'hFFF, 1'b1, 12'hFFF},
        '{ROW_SAMPLE, 12'h000, 1'b0, 12'h000},
        '{ROW_SAMPLE, 12'h000, 1'b0, 12'h000},
        '{ROW_SAMPLE, 12'h000, 1'b0, 12'h000}
    };

    logic             clk;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [CFG_W-1:0] cfg_length;

    mavf_sample_if  smp ();
    mavf_average_if avg ();

    moving_average_filter_unit #(
        .MAX_WINDOW    (MAX_WINDOW)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .sample_ch     (smp),
        .average_ch    (avg),
        .cfg_wr_en     (cfg_wr_en),
        .window_length (cfg_length)
    );

    // Shadow copy of the filter state.
    logic [SAMPLE_W-1:0] win_ring [MAX_WINDOW];
    int unsigned         win_sum;
    int unsigned         win_pos;
    int unsigned         win_len;
    bit                  win_primed;

    logic [SAMPLE_W-1:0] pending_averages [$];

    bit          gapless;
    bit          hold_off_pending;
    int unsigned errors;
    int unsigned samples_sent;
    int unsigned averages_checked;
    int unsigned length_writes;
    bit          lengths_seen [1:MAX_WINDOW];

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    task automatic report_mismatch(input string msg);
        errors++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    function automatic void apply_length_write(input logic [CFG_W-1:0] value);
        int unsigned n;
        n = value;
        if (n == win_len)
            return;
        if (n < 1)
            n = 1;
        else if (n > MAX_WINDOW)
            n = MAX_WINDOW;
        win_len    = n;
        win_primed = 1'b0;
    endfunction

    function automatic logic [SAMPLE_W-1:0] advance_window(input logic [SAMPLE_W-1:0] s);
        int unsigned i;
        lengths_seen[win_len] = 1'b1;
        if (!win_primed)
        begin
            for (i = 0; i < win_len; i++)
                win_ring[i] = s;
            win_sum    = s * win_len;
            win_pos    = 0;
            win_primed = 1'b1;
        end
        win_sum           = win_sum - win_ring[win_pos] + s;
        win_ring[win_pos] = s;
        win_pos           = (win_pos + 1 >= win_len) ? 0 : win_pos + 1;
        return SAMPLE_W'((win_sum + win_len / 2) / win_len);
    endfunction

    task automatic send_sample(input logic [SAMPLE_W-1:0] s, input bit has_exp,
                               input logic [SAMPLE_W-1:0] exp);
        int unsigned         gap;
        logic [SAMPLE_W-1:0] predicted;
        gap = gapless ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            smp.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        smp.valid  <= 1'b1;
        smp.sample <= s;
        @(posedge clk);
        while (!smp.ready)
            @(posedge clk);
        predicted = advance_window(s);
        pending_averages.push_back(has_exp ? exp : predicted);
        samples_sent++;
    endtask

    // The block is idle once every average is back and its last slot has run out.
    task automatic wait_for_drain();
        smp.valid <= 1'b0;
        while (pending_averages.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_length(input logic [CFG_W-1:0] value);
        wait_for_drain();
        cfg_wr_en  <= 1'b1;
        cfg_length <= value;
        @(posedge clk);
        cfg_wr_en  <= 1'b0;
        apply_length_write(value);
        length_writes++;
    endtask

    function automatic logic [SAMPLE_W-1:0] random_sample();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return SAMPLE_W'($urandom_range(0, SAMPLE_RANGE - 1));
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] random_length();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return CFG_W'(1);
            2:       return CFG_W'(MAX_WINDOW);
            3:       return '1;
            4:       return CFG_W'(win_len);
            5:       return CFG_W'($urandom_range(MAX_WINDOW + 1, (1 << CFG_W) - 1));
            6:       return CFG_W'($urandom_range(1, 8));
            default: return CFG_W'($urandom_range(1, MAX_WINDOW));
        endcase
    endfunction

    initial
    begin : average_sink
        int unsigned         hold;
        logic [SAMPLE_W-1:0] want;
        @(posedge clk iff rst_n);
        forever
        begin
            hold = gapless ? 0 : $urandom_range(0, 8);
            if (hold_off_pending)
            begin
                hold             = LONG_HOLD;
                hold_off_pending = 1'b0;
            end
            avg.ready <= (hold == 0);
            if (hold > 0)
            begin
                repeat (hold) @(posedge clk);
                avg.ready <= 1'b1;
            end
            @(posedge clk);
            while (!avg.valid)
                @(posedge clk);
            if (pending_averages.size() == 0)
                report_mismatch($sformatf("average %0d with no request outstanding",
                                          avg.average));
            else
            begin
                want = pending_averages.pop_front();
                if (avg.average !== want)
                    report_mismatch($sformatf("average got %0d, want %0d",
                                              avg.average, want));
                averages_checked++;
            end
        end
    end

    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        @(posedge clk iff rst_n);
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((smp.valid && smp.ready) || (avg.valid && avg.ready) || cfg_wr_en)
                quiet = 0;
            else
                quiet++;
        end
        $display("[%0t] no request accepted for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin : stimulus
        int unsigned random_sent;
        int unsigned phase;
        int unsigned phase_items;
        int unsigned distinct;
        rst_n            = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_length       = '0;
        smp.valid        = 1'b0;
        smp.sample       = '0;
        avg.ready        = 1'b0;
        gapless          = 1'b0;
        hold_off_pending = 1'b0;
        errors           = 0;
        samples_sent     = 0;
        averages_checked = 0;
        length_writes    = 0;
        win_sum          = 0;
        win_pos          = 0;
        win_len          = MAX_WINDOW;
        win_primed       = 1'b0;
        foreach (win_ring[i])
            win_ring[i] = '0;
        foreach (lengths_seen[i])
            lengths_seen[i] = 1'b0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_steps[i])
        begin
            if (directed_steps[i].kind == ROW_LENGTH)
                write_length(directed_steps[i].value[CFG_W-1:0]);
            else
                send_sample(directed_steps[i].value, directed_steps[i].has_exp,
                            directed_steps[i].exp);
        end

        random_sent = 0;
        phase       = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            write_length(random_length());
            phase_items = $urandom_range(20, 150);
            gapless     = ($urandom_range(0, 3) == 0);
            // The first phase backs up the output so the input has to stall.
            if (phase == 0)
            begin
                gapless          = 1'b1;
                hold_off_pending = 1'b1;
                phase_items      = 120;
            end
            repeat (phase_items)
                send_sample(random_sample(), 1'b0, '0);
            random_sent += phase_items;
            phase++;
        end

        gapless = 1'b0;
        wait_for_drain();

        distinct = 0;
        foreach (lengths_seen[i])
            distinct += lengths_seen[i];
        $display("Run covered %0d samples in %0d random phases and %0d length writes.",
                 samples_sent, phase, length_writes);
        $display("Checked %0d averages over %0d distinct window lengths, %0d mismatches.",
                 averages_checked, distinct, errors);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
